[hdl/ep2cal_pkg.sv]
// Shared types, constants, calendar tables and the control program of the epoch-to-calendar block.
package ep2cal_pkg;

    // Bias that moves any signed 32-bit count to a positive 33-bit value: 24856 whole days.
    localparam logic [33:0]        EPOCH_BIAS = 34'h0_8001_2400;
    localparam logic signed [17:0] DAY_BIAS   = 18'sd24856;
    // Seconds per day with the low seven bits split off: 86400 = 675 * 128.
    localparam logic [9:0]         DAY_DIV    = 10'd675;
    // ceil(2^36 / 675): exact quotient for any 26-bit dividend.
    localparam logic [26:0]        DAY_RECIP  = 27'd101806633;
    localparam logic [11:0]        HOUR_SECS  = 12'd3600;
    // ceil(2^21 / 225), applied to the seconds of the day over 16.
    localparam logic [13:0]        HOUR_RECIP = 14'd9321;
    localparam logic [5:0]         MIN_SECS   = 6'd60;
    // ceil(2^14 / 15), applied to the seconds of the hour over 4.
    localparam logic [10:0]        MIN_RECIP  = 11'd1093;
    localparam logic [7:0]         BASE_YEAR  = 8'd70;   // 1970 less 1900
    // The biased day count is 6 mod 7 at epoch and epoch is a Thursday, so add 5.
    localparam logic [2:0]         WD_OFFSET  = 3'd5;
    // ceil(2^19 / 7): exact quotient for any 17-bit dividend up to 104857.
    localparam logic [16:0]        WD_RECIP   = 17'd74899;
    localparam logic [3:0]         LAST_MONTH = 4'd11;

    typedef logic [3:0] t_pc;

    localparam t_pc PC_IDLE  = 4'd0;
    localparam t_pc PC_DIV   = 4'd1;
    localparam t_pc PC_SPLIT = 4'd2;
    localparam t_pc PC_HOUR  = 4'd3;
    localparam t_pc PC_HREM  = 4'd4;
    localparam t_pc PC_MIN   = 4'd5;
    localparam t_pc PC_SEC   = 4'd6;
    localparam t_pc PC_YUP   = 4'd7;
    localparam t_pc PC_YDN   = 4'd8;
    localparam t_pc PC_DOY   = 4'd9;
    localparam t_pc PC_MWALK = 4'd10;
    localparam t_pc PC_DONE  = 4'd11;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_DIV,
        OP_SPLIT,
        OP_HOUR,
        OP_HREM,
        OP_MIN,
        OP_SEC,
        OP_YUP,
        OP_YDN,
        OP_DOY,
        OP_MWALK,
        OP_DONE,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ACCEPT,
        COND_YUP,
        COND_YDN,
        COND_MON,
        COND_OUT
    } t_cond;

    typedef struct packed {
        t_op        op;
        t_cond      cond;
        t_pc        target;
    } t_uword;

    typedef struct packed {
        t_op        op;
        logic       load;
        logic       emit;
        logic       idle;
    } t_ctrl;

    typedef struct packed {
        logic year_up;
        logic neg;
        logic mon_go;
    } t_status;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [3:0] month;
        logic [4:0] day_of_month;
    } t_result;

    // Year held as offset from 1900; 1900 itself is not a leap year.
    function automatic logic is_leap(input logic [7:0] y);
        is_leap = (y[1:0] == 2'b00) && (y != 8'd0);
    endfunction

    function automatic logic [8:0] year_len(input logic [7:0] y);
        year_len = is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
        logic [4:0] len;
        unique case (mon)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        month_len = len;
    endfunction

    function automatic t_uword uword(input t_op op, input t_cond cond, input t_pc target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        uword = w;
    endfunction

    // Control store.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:  w = uword(OP_IDLE,  COND_ACCEPT, PC_DIV);
            PC_DIV:   w = uword(OP_DIV,   COND_NEXT,   PC_SPLIT);
            PC_SPLIT: w = uword(OP_SPLIT, COND_NEXT,   PC_HOUR);
            PC_HOUR:  w = uword(OP_HOUR,  COND_NEXT,   PC_HREM);
            PC_HREM:  w = uword(OP_HREM,  COND_NEXT,   PC_MIN);
            PC_MIN:   w = uword(OP_MIN,   COND_NEXT,   PC_SEC);
            PC_SEC:   w = uword(OP_SEC,   COND_NEXT,   PC_YUP);
            PC_YUP:   w = uword(OP_YUP,   COND_YUP,    PC_YUP);
            PC_YDN:   w = uword(OP_YDN,   COND_YDN,    PC_YDN);
            PC_DOY:   w = uword(OP_DOY,   COND_NEXT,   PC_MWALK);
            PC_MWALK: w = uword(OP_MWALK, COND_MON,    PC_MWALK);
            PC_DONE:  w = uword(OP_DONE,  COND_OUT,    PC_IDLE);
            default:  w = uword(OP_NOP,   COND_OUT,    PC_IDLE);
        endcase
        ucode = w;
    endfunction

endpackage

[hdl/ep2cal_if.sv]
// Valid/ready channel interfaces for the epoch input and the calendar result.
interface ep2cal_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ep2cal_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] years_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month;
    logic [4:0] day_of_month;

    modport source (output valid, output second, output minute, output hour, output weekday,
                    output years_since_1900, output day_of_year, output month,
                    output day_of_month, input ready);
    modport sink   (input valid, input second, input minute, input hour, input weekday,
                    input years_since_1900, input day_of_year, input month,
                    input day_of_month, output ready);
endinterface

[hdl/ep2cal_useq.sv]
// Microprogram sequencer: step counter and conditional jumps over the control store.
module ep2cal_useq import ep2cal_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_out_free,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_pc        r_pc;
    t_pc        n_pc;
    t_uword     uw;

    always_comb begin
        uw    = ucode(r_pc);
        n_pc  = r_pc + 4'd1;
        unique case (uw.cond)
            COND_NEXT: begin
            end
            COND_ACCEPT: begin
                if (!i_accept) begin
                    n_pc = r_pc;
                end
            end
            COND_YUP: begin
                if (i_status.year_up) begin
                    n_pc = uw.target;
                end
            end
            COND_YDN: begin
                if (i_status.neg) begin
                    n_pc = uw.target;
                end
            end
            COND_MON: begin
                if (i_status.mon_go) begin
                    n_pc = uw.target;
                end
            end
            COND_OUT: begin
                n_pc = i_out_free ? uw.target : r_pc;
            end
            default: begin
                n_pc = PC_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl.op   = uw.op;
        o_ctrl.idle = (r_pc == PC_IDLE);
        o_ctrl.load = (uw.op == OP_IDLE) && i_accept;
        o_ctrl.emit = (uw.op == OP_DONE) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_IDLE;
        end else begin
            r_pc  <= n_pc;
        end
    end

endmodule

[hdl/ep2cal_dpath.sv]
// Datapath: day division, time-of-day split, year and month walks under microcode control.
module ep2cal_dpath import ep2cal_pkg::*; (
    input  logic               i_clk,
    input  t_ctrl              i_ctrl,
    input  logic signed [31:0] i_epoch_seconds,
    output t_status            o_status,
    output t_result            o_result
);

    logic [25:0]        r_num;
    logic [6:0]         r_lo7;
    logic [16:0]        r_q;
    logic [16:0]        r_acc;
    logic [2:0]         r_wd;
    logic signed [16:0] r_days;
    logic [7:0]         r_year;
    logic [3:0]         r_mon;
    logic [8:0]         r_doy;
    logic [4:0]         r_hour;
    logic [5:0]         r_min;
    logic [5:0]         r_sec;

    logic [33:0]        biased;
    logic [52:0]        day_prod;
    logic [25:0]        day_back;
    logic [25:0]        day_rem;
    logic [16:0]        wd_num;
    logic [33:0]        wd_prod;
    logic [13:0]        wd_quot;
    logic [16:0]        wd_fold;
    logic [26:0]        hour_prod;
    logic [16:0]        hour_back;
    logic [20:0]        min_prod;
    logic [11:0]        min_back;
    logic [11:0]        sec_full;
    logic signed [17:0] days_full;
    logic signed [16:0] ylen_s;
    logic signed [16:0] ylen_prev_s;
    logic [7:0]         year_prev;
    logic signed [16:0] mlen_s;

    assign biased    = {{2{i_epoch_seconds[31]}}, i_epoch_seconds} + EPOCH_BIAS;
    // quotient by reciprocal multiply, remainder by multiply back
    assign day_prod  = {27'd0, r_num} * {26'd0, DAY_RECIP};
    assign day_back  = {9'd0, r_q} * {16'd0, DAY_DIV};
    assign day_rem   = r_num - day_back;
    assign wd_num    = r_q + {14'd0, WD_OFFSET};
    assign wd_prod   = {17'd0, wd_num} * {17'd0, WD_RECIP};
    assign wd_quot   = wd_prod[32:19];
    assign wd_fold   = wd_num - {wd_quot, 3'b000} + {3'b000, wd_quot};
    assign hour_prod = {14'd0, r_acc[16:4]} * {13'd0, HOUR_RECIP};
    assign hour_back = {12'd0, r_hour} * {5'd0, HOUR_SECS};
    assign min_prod  = {11'd0, r_acc[11:2]} * {10'd0, MIN_RECIP};
    assign min_back  = {6'd0, r_min} * {6'd0, MIN_SECS};
    assign sec_full  = r_acc[11:0] - min_back;
    assign days_full = $signed({1'b0, r_q}) - DAY_BIAS;
    assign year_prev = r_year - 8'd1;
    assign ylen_s    = $signed({8'd0, year_len(r_year)});
    assign ylen_prev_s = $signed({8'd0, year_len(year_prev)});
    assign mlen_s    = $signed({12'd0, month_len(is_leap(r_year), r_mon)});

    assign o_status.year_up = (r_days >= ylen_s);
    assign o_status.neg     = r_days[16];
    assign o_status.mon_go  = (r_mon < LAST_MONTH) && (r_days >= mlen_s);

    always_comb begin
        o_result.second           = r_sec;
        o_result.minute           = r_min;
        o_result.hour             = r_hour;
        o_result.weekday          = r_wd;
        o_result.years_since_1900 = r_year;
        o_result.day_of_year      = r_doy;
        o_result.month            = r_mon;
        o_result.day_of_month     = r_days[4:0] + 5'd1;
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            OP_IDLE: begin
                if (i_ctrl.load) begin
                    r_num <= biased[32:7];
                    r_lo7 <= biased[6:0];
                end
            end
            OP_DIV: begin
                r_q <= day_prod[52:36];
            end
            OP_SPLIT: begin
                r_acc  <= {day_rem[9:0], r_lo7};
                r_wd   <= wd_fold[2:0];
                r_days <= days_full[16:0];
                r_year <= BASE_YEAR;
            end
            OP_HOUR: begin
                r_hour <= hour_prod[25:21];
            end
            OP_HREM: begin
                r_acc <= r_acc - hour_back;
            end
            OP_MIN: begin
                r_min <= min_prod[19:14];
            end
            OP_SEC: begin
                r_sec <= sec_full[5:0];
            end
            OP_YUP: begin
                if (o_status.year_up) begin
                    r_days <= r_days - ylen_s;
                    r_year <= r_year + 8'd1;
                end
            end
            OP_YDN: begin
                if (o_status.neg) begin
                    r_days <= r_days + ylen_prev_s;
                    r_year <= year_prev;
                end
            end
            OP_DOY: begin
                r_doy <= r_days[8:0];
                r_mon <= 4'd0;
            end
            OP_MWALK: begin
                if (o_status.mon_go) begin
                    r_days <= r_days - mlen_s;
                    r_mon  <= r_mon + 4'd1;
                end
            end
            OP_NOP, OP_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

[hdl/epoch_seconds_to_calendar_top.sv]
// Top level: epoch seconds to broken-down UTC calendar time, with result register.
//
//  Channel  Dir  Handshake              Payload
//  i_req    in   i_req.valid/ready      epoch_seconds (signed 32)
//  o_rsp    out  o_rsp.valid/ready      second, minute, hour, weekday, years_since_1900,
//                                       day_of_year, month, day_of_month
//
// One transaction at a time; after acceptance the sequencer runs six fixed steps (day split,
// time of day, weekday), one step per year walked from 1970 (up to 68 up or 69 down) plus
// two checks, one per month walked (up to 11) plus a check, and the day-of-year and output
// steps. The next transaction is taken only once the sequencer is back in idle.
// Synchronous active-low reset returns the sequencer to idle and empties the result register.
// A stalled output holds the sequencer in its final step until the register frees.
module epoch_seconds_to_calendar_top import ep2cal_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ep2cal_in_if.sink    i_req,
    ep2cal_out_if.source o_rsp
);

    t_ctrl   ctrl;
    t_status status;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    accept;
    logic    out_free;

    assign accept   = i_req.valid && ctrl.idle;
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready = ctrl.idle;

    ep2cal_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_out_free (out_free),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    ep2cal_dpath u_dpath (
        .i_clk           (i_clk),
        .i_ctrl          (ctrl),
        .i_epoch_seconds (i_req.epoch_seconds),
        .o_status        (status),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.second           = r_out.second;
    assign o_rsp.minute           = r_out.minute;
    assign o_rsp.hour             = r_out.hour;
    assign o_rsp.weekday          = r_out.weekday;
    assign o_rsp.years_since_1900 = r_out.years_since_1900;
    assign o_rsp.day_of_year      = r_out.day_of_year;
    assign o_rsp.month            = r_out.month;
    assign o_rsp.day_of_month     = r_out.day_of_month;

endmodule
